### rtl/tqv_pkg.sv
// Package for the tabular Q-value engine: item types, codes, controller states
// and the command and status groups between controller and datapath.
// No dependencies.
package tqv_pkg;

  typedef enum logic [2:0] {
    KIND_SELECT      = 3'd0,
    KIND_SARSA       = 3'd1,
    KIND_QLEARN      = 3'd2,
    KIND_TERM_Q      = 3'd3,
    KIND_DOUBLE      = 3'd4,
    KIND_TERM_DOUBLE = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_SAT   = 2'd2
  } status_t;

  localparam logic [7:0] CFG_EXPLORE     = 8'd0;
  localparam logic [7:0] CFG_STEP        = 8'd1;
  localparam logic [7:0] CFG_DISCOUNT    = 8'd2;
  localparam logic [7:0] CFG_SEL_DOUBLE  = 8'd3;

  localparam logic [16:0] RST_EXPLORE  = 17'd0;
  localparam logic [16:0] RST_STEP     = 17'd6554;
  localparam logic [16:0] RST_DISCOUNT = 17'd58982;

  typedef enum logic [1:0] {
    MODE_Q   = 2'd0,
    MODE_SUM = 2'd1,
    MODE_QA  = 2'd2,
    MODE_QB  = 2'd3
  } scan_mode_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_SCAN_END,
    ST_RD_NEXT,
    ST_CAP_NEXT,
    ST_RD_CUR,
    ST_CAP_CUR,
    ST_DIFF,
    ST_MUL,
    ST_WB,
    ST_MOD,
    ST_DONE
  } ctl_state_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [7:0]        cur_state;
    logic [2:0]        action;
    logic signed [31:0] reward;
    logic [7:0]        next_state;
    logic [2:0]        next_action;
    logic [7:0]        allowed_mask;
    logic [15:0]       explore_draw;
    logic [15:0]       pick_draw;
    logic              which_table;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         chosen_action;
    logic signed [31:0] new_value;
    logic               explored;
    logic [1:0]         status;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic clr;
    logic scan_rd;
    logic rd_next;
    logic cap_next;
    logic rd_cur;
    logic cap_cur;
    logic diff;
    logic mul;
    logic wb;
    logic mod_init;
    logic mod_step;
    logic finish;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  mask_empty;
    logic  explore;
    logic  clr_last;
    logic  scan_last;
    logic  mod_last;
    logic  pass_last;
    logic  out_busy;
  } ctl_stat_t;

endpackage

### rtl/tqv_if.sv
// Channel interfaces of the tabular Q-value engine: input items, results and
// configuration writes. No dependencies.
interface tqv_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         kind;
  logic [7:0]         cur_state;
  logic [2:0]         action;
  logic signed [31:0] reward;
  logic [7:0]         next_state;
  logic [2:0]         next_action;
  logic [7:0]         allowed_mask;
  logic [15:0]        explore_draw;
  logic [15:0]        pick_draw;
  logic               which_table;

  modport source (output valid, kind, cur_state, action, reward, next_state, next_action,
                  allowed_mask, explore_draw, pick_draw, which_table, input ready);
  modport sink (input valid, kind, cur_state, action, reward, next_state, next_action,
                allowed_mask, explore_draw, pick_draw, which_table, output ready);
endinterface

interface tqv_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         chosen_action;
  logic signed [31:0] new_value;
  logic               explored;
  logic [1:0]         status;

  modport source (output valid, chosen_action, new_value, explored, status, input ready);
  modport sink (input valid, chosen_action, new_value, explored, status, output ready);
endinterface

interface tqv_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [16:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/tqv_datapath.sv
// Datapath of the tabular Q-value engine: value tables, configuration registers,
// argmax scan, remainder unit and update arithmetic. Depends on tqv_pkg.
module tqv_datapath #(
  parameter int NUM_STATES  = 256,
  parameter int NUM_ACTIONS = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  tqv_pkg::in_item_t  in_item,
  input  logic               cfg_valid,
  input  logic [7:0]         cfg_index,
  input  logic [16:0]        cfg_data,
  input  tqv_pkg::ctl_cmd_t  cmd,
  output tqv_pkg::ctl_stat_t stat,
  output tqv_pkg::out_item_t out_item,
  output logic               out_valid,
  input  logic               out_ready
);
  import tqv_pkg::*;

  localparam int DEPTH = NUM_STATES * NUM_ACTIONS;
  localparam int AW = $clog2(DEPTH);
  localparam int NSCAN = (NUM_ACTIONS < 8) ? NUM_ACTIONS : 8;
  localparam logic [7:0] MASK_LIM = (NUM_ACTIONS >= 8) ? 8'hFF : 8'((1 << NUM_ACTIONS) - 1);
  localparam logic [16:0] S_RECIP = 17'((65536 + NUM_STATES - 1) / NUM_STATES);
  localparam logic [16:0] A_RECIP = 17'((65536 + NUM_ACTIONS - 1) / NUM_ACTIONS);

  function automatic logic [15:0] reduce_idx(input logic [7:0] v, input logic [16:0] recip,
                                             input logic [15:0] n);
    logic [24:0] prod;
    logic [15:0] quot_n;
    logic [15:0] rem;
    prod = {17'b0, v} * {8'b0, recip};
    quot_n = 16'(prod[24:16]) * n;
    rem = {8'b0, v} - quot_n;
    if (rem >= n) begin
      rem = rem - n;
    end
    return rem;
  endfunction

  logic [31:0] q_mem  [DEPTH];
  logic [31:0] qa_mem [DEPTH];
  logic [31:0] qb_mem [DEPTH];
  logic signed [31:0] q_rd_r, qa_rd_r, qb_rd_r;

  logic [16:0] explore_thr_r, step_r, discount_r;
  logic        sel_double_r;

  kind_t              kind_r;
  logic [7:0]         mask_r;
  logic signed [31:0] reward_r;
  logic               which_r;
  logic [15:0]        pdraw_r;
  logic               explore_r;
  scan_mode_t         mode_r;
  logic [AW-1:0]      cur_addr_r, nxt_addr_r, scan_base_r, clr_cnt_r;
  logic [2:0]         scan_col_r, scan_pcol_r, best_idx_r;
  logic               scan_pend_r, found_r, pass_r;
  logic signed [32:0] best_val_r;
  logic signed [31:0] boot_r, olda_r, oldb_r, res_val_r;
  logic               sat_r;
  logic signed [49:0] disc_prod_r;
  logic signed [34:0] target_r;
  logic signed [35:0] diff_r;
  logic signed [53:0] mul_r;
  logic [3:0]         rem_r, mod_cnt_r;
  logic               out_valid_r;
  out_item_t          out_r;

  logic [15:0]        s_red, sn_red, a_red, an_red;
  logic [AW-1:0]      s_base, sn_base, rd_addr, wr_addr;
  logic signed [32:0] mode_val;
  logic signed [31:0] boot_val, old_sel, nv;
  logic signed [49:0] disc_sum;
  logic signed [33:0] disc_round;
  logic signed [53:0] mul_sum;
  logic signed [37:0] mul_round;
  logic signed [38:0] upd;
  logic               pos_ovf, neg_ovf, boot_en;
  logic               we_q, we_a, we_b;
  logic [31:0]        wr_data;
  logic [3:0]         cnt;
  logic [4:0]         rem_shift;
  logic [3:0]         rank_k;
  logic [2:0]         pick;
  logic               hit, mask_empty;
  scan_mode_t         mode_nxt;

  always_comb begin
    s_red   = reduce_idx(in_item.cur_state, S_RECIP, 16'(NUM_STATES));
    sn_red  = reduce_idx(in_item.next_state, S_RECIP, 16'(NUM_STATES));
    a_red   = reduce_idx({5'b0, in_item.action}, A_RECIP, 16'(NUM_ACTIONS));
    an_red  = reduce_idx({5'b0, in_item.next_action}, A_RECIP, 16'(NUM_ACTIONS));
    s_base  = AW'(32'(s_red) * 32'(NUM_ACTIONS));
    sn_base = AW'(32'(sn_red) * 32'(NUM_ACTIONS));
    case (kind_t'(in_item.kind))
      KIND_SELECT: mode_nxt = sel_double_r ? MODE_SUM : MODE_Q;
      KIND_DOUBLE: mode_nxt = in_item.which_table ? MODE_QB : MODE_QA;
      default:     mode_nxt = MODE_Q;
    endcase
  end

  always_comb begin
    case (mode_r)
      MODE_SUM: mode_val = 33'(qa_rd_r) + 33'(qb_rd_r);
      MODE_QA:  mode_val = 33'(qa_rd_r);
      MODE_QB:  mode_val = 33'(qb_rd_r);
      default:  mode_val = 33'(q_rd_r);
    endcase
    case (mode_r)
      MODE_QA: boot_val = qb_rd_r;
      MODE_QB: boot_val = qa_rd_r;
      default: boot_val = q_rd_r;
    endcase
  end

  always_comb begin
    old_sel    = pass_r ? oldb_r : olda_r;
    disc_sum   = disc_prod_r + 50'sd32768;
    disc_round = disc_sum[49:16];
    mul_sum    = mul_r + 54'sd32768;
    mul_round  = mul_sum[53:16];
    upd        = 39'(old_sel) + 39'(mul_round);
    pos_ovf    = !upd[38] && (|upd[37:31]);
    neg_ovf    = upd[38] && !(&upd[37:31]);
    if (pos_ovf) begin
      nv = 32'sh7FFFFFFF;
    end else if (neg_ovf) begin
      nv = 32'sh80000000;
    end else begin
      nv = upd[31:0];
    end
    boot_en = (kind_r == KIND_SARSA) || (kind_r == KIND_QLEARN) || (kind_r == KIND_DOUBLE);
  end

  always_comb begin
    we_q = cmd.clr || (cmd.wb && ((kind_r == KIND_SARSA) || (kind_r == KIND_QLEARN) ||
                                  (kind_r == KIND_TERM_Q)));
    we_a = cmd.clr || (cmd.wb && (((kind_r == KIND_DOUBLE) && !which_r) ||
                                  ((kind_r == KIND_TERM_DOUBLE) && !pass_r)));
    we_b = cmd.clr || (cmd.wb && (((kind_r == KIND_DOUBLE) && which_r) ||
                                  ((kind_r == KIND_TERM_DOUBLE) && pass_r)));
    wr_data = cmd.clr ? 32'd0 : nv;
    wr_addr = cmd.clr ? clr_cnt_r : cur_addr_r;
    if (cmd.scan_rd) begin
      rd_addr = scan_base_r + AW'(scan_col_r);
    end else if (cmd.rd_next) begin
      rd_addr = nxt_addr_r;
    end else begin
      rd_addr = cur_addr_r;
    end
  end

  always_ff @(posedge clk) begin
    if (we_q) begin
      q_mem[wr_addr] <= wr_data;
    end
    if (we_a) begin
      qa_mem[wr_addr] <= wr_data;
    end
    if (we_b) begin
      qb_mem[wr_addr] <= wr_data;
    end
    q_rd_r  <= q_mem[rd_addr];
    qa_rd_r <= qa_mem[rd_addr];
    qb_rd_r <= qb_mem[rd_addr];
  end

  always_comb begin
    cnt = 4'd0;
    for (int j = 0; j < 8; j++) begin
      cnt = cnt + 4'(mask_r[j]);
    end
    mask_empty = (mask_r == 8'd0);
    rem_shift = {rem_r, pdraw_r[15]};
    rank_k = 4'd0;
    pick = 3'd0;
    hit = 1'b0;
    for (int j = 0; j < 8; j++) begin
      if (mask_r[j]) begin
        if (!hit && (rank_k == rem_r)) begin
          pick = 3'(j);
          hit = 1'b1;
        end
        rank_k = rank_k + 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      explore_thr_r <= RST_EXPLORE;
      step_r        <= RST_STEP;
      discount_r    <= RST_DISCOUNT;
      sel_double_r  <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_EXPLORE:    explore_thr_r <= cfg_data;
        CFG_STEP:       step_r <= cfg_data;
        CFG_DISCOUNT:   discount_r <= cfg_data;
        CFG_SEL_DOUBLE: sel_double_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r   <= '0;
      scan_pend_r <= 1'b0;
      scan_col_r  <= 3'd0;
      mod_cnt_r   <= 4'd0;
      pass_r      <= 1'b0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      kind_r      <= KIND_SELECT;
    end else begin
      scan_pend_r <= cmd.scan_rd;
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
      if (cmd.load) begin
        kind_r     <= kind_t'(in_item.kind);
        scan_col_r <= 3'd0;
        pass_r     <= 1'b0;
        found_r    <= 1'b0;
      end
      if (cmd.scan_rd) begin
        scan_col_r <= scan_col_r + 3'd1;
      end
      if (scan_pend_r && mask_r[scan_pcol_r] && (!found_r || (mode_val > best_val_r))) begin
        found_r <= 1'b1;
      end
      if (cmd.wb) begin
        pass_r <= 1'b1;
      end
      if (cmd.mod_init) begin
        mod_cnt_r <= 4'd0;
      end else if (cmd.mod_step) begin
        mod_cnt_r <= mod_cnt_r + 4'd1;
      end
      if (cmd.finish) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    scan_pcol_r <= scan_col_r;
    if (cmd.load) begin
      mask_r      <= in_item.allowed_mask & MASK_LIM;
      reward_r    <= in_item.reward;
      which_r     <= in_item.which_table;
      pdraw_r     <= in_item.pick_draw;
      explore_r   <= ({1'b0, in_item.explore_draw} < explore_thr_r);
      mode_r      <= mode_nxt;
      cur_addr_r  <= s_base + AW'(a_red);
      nxt_addr_r  <= sn_base + AW'(an_red);
      scan_base_r <= (kind_t'(in_item.kind) == KIND_SELECT) ? s_base : sn_base;
      best_idx_r  <= 3'd0;
      res_val_r   <= 32'sd0;
      sat_r       <= 1'b0;
    end
    if (scan_pend_r && mask_r[scan_pcol_r] && (!found_r || (mode_val > best_val_r))) begin
      best_val_r <= mode_val;
      best_idx_r <= scan_pcol_r;
      boot_r     <= boot_val;
    end else if (cmd.cap_next) begin
      boot_r <= q_rd_r;
    end
    if (cmd.rd_cur) begin
      disc_prod_r <= boot_r * $signed({1'b0, discount_r});
    end
    if (cmd.cap_cur) begin
      if ((kind_r == KIND_DOUBLE) && which_r) begin
        olda_r <= qb_rd_r;
      end else if ((kind_r == KIND_DOUBLE) || (kind_r == KIND_TERM_DOUBLE)) begin
        olda_r <= qa_rd_r;
      end else begin
        olda_r <= q_rd_r;
      end
      oldb_r   <= qb_rd_r;
      target_r <= 35'(reward_r) + (boot_en ? 35'(disc_round) : 35'sd0);
    end
    if (cmd.diff) begin
      diff_r <= 36'(target_r) - 36'(old_sel);
    end
    if (cmd.mul) begin
      mul_r <= diff_r * $signed({1'b0, step_r});
    end
    if (cmd.wb) begin
      if ((kind_r != KIND_TERM_DOUBLE) || (pass_r == which_r)) begin
        res_val_r <= nv;
      end
      if (pos_ovf || neg_ovf) begin
        sat_r <= 1'b1;
      end
    end
    if (cmd.mod_init) begin
      rem_r <= 4'd0;
    end else if (cmd.mod_step) begin
      rem_r   <= (rem_shift >= 5'(cnt)) ? 4'(rem_shift - 5'(cnt)) : rem_shift[3:0];
      pdraw_r <= {pdraw_r[14:0], 1'b0};
    end
    if (cmd.finish) begin
      out_r.new_value <= res_val_r;
      if (mask_empty && ((kind_r == KIND_SELECT) || (kind_r == KIND_QLEARN) ||
                         (kind_r == KIND_DOUBLE))) begin
        out_r.chosen_action <= 3'd0;
        out_r.explored      <= 1'b0;
        out_r.status        <= STATUS_EMPTY;
      end else if (kind_r == KIND_SELECT) begin
        out_r.chosen_action <= explore_r ? pick : best_idx_r;
        out_r.explored      <= explore_r;
        out_r.status        <= sat_r ? STATUS_SAT : STATUS_OK;
      end else begin
        out_r.chosen_action <= 3'd0;
        out_r.explored      <= 1'b0;
        out_r.status        <= sat_r ? STATUS_SAT : STATUS_OK;
      end
    end
  end

  always_comb begin
    stat.kind       = kind_r;
    stat.mask_empty = mask_empty;
    stat.explore    = explore_r;
    stat.clr_last   = (clr_cnt_r == AW'(DEPTH - 1));
    stat.scan_last  = (scan_col_r == 3'(NSCAN - 1));
    stat.mod_last   = (mod_cnt_r == 4'd15);
    stat.pass_last  = (kind_r != KIND_TERM_DOUBLE) || pass_r;
    stat.out_busy   = out_valid_r && !out_ready;
    out_valid       = out_valid_r;
    out_item        = out_r;
  end

endmodule

### rtl/tqv_controller.sv
// Controller of the tabular Q-value engine: sequences the clearing pass and the
// phases of each item. Depends on tqv_pkg.
module tqv_controller (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  tqv_pkg::ctl_stat_t stat,
  output tqv_pkg::ctl_cmd_t  cmd
);
  import tqv_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (stat.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat.kind)
          KIND_SELECT: begin
            if (stat.mask_empty) begin
              state_nxt = ST_DONE;
            end else if (stat.explore) begin
              cmd.mod_init = 1'b1;
              state_nxt = ST_MOD;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
          KIND_SARSA: state_nxt = ST_RD_NEXT;
          KIND_QLEARN, KIND_DOUBLE: begin
            state_nxt = stat.mask_empty ? ST_DONE : ST_SCAN;
          end
          KIND_TERM_Q, KIND_TERM_DOUBLE: state_nxt = ST_RD_CUR;
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (stat.scan_last) begin
          state_nxt = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_nxt = (stat.kind == KIND_SELECT) ? ST_DONE : ST_RD_CUR;
      end
      ST_RD_NEXT: begin
        cmd.rd_next = 1'b1;
        state_nxt = ST_CAP_NEXT;
      end
      ST_CAP_NEXT: begin
        cmd.cap_next = 1'b1;
        state_nxt = ST_RD_CUR;
      end
      ST_RD_CUR: begin
        cmd.rd_cur = 1'b1;
        state_nxt = ST_CAP_CUR;
      end
      ST_CAP_CUR: begin
        cmd.cap_cur = 1'b1;
        state_nxt = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff = 1'b1;
        state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_WB;
      end
      ST_WB: begin
        cmd.wb = 1'b1;
        state_nxt = stat.pass_last ? ST_DONE : ST_DIFF;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
        if (stat.mod_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!stat.out_busy) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

### rtl/tabular_q_value_engine_top.sv
// Top level of the tabular Q-value engine: controller and datapath joined by
// command and status groups. Depends on tqv_pkg, tqv_if, tqv_controller, tqv_datapath.
//
//   Channel  Role  Moves per transfer
//   in_ch    sink  one item: kind, states, actions, reward, mask, draws, table
//   out_ch   src   one result: chosen_action, new_value, explored, status
//   cfg_ch   sink  one register write: index and data, always ready
//
// N = min(NUM_ACTIONS, 8) actions are scanned one per cycle; a random select runs
// a 16-step remainder instead. After reset the tables are cleared one entry per
// cycle, all NUM_STATES*NUM_ACTIONS entries, with in_ch.ready low. A result
// waits in the output register; a stalled result only holds the next one.
module tabular_q_value_engine_top #(
  parameter int NUM_STATES  = 256,
  parameter int NUM_ACTIONS = 8
) (
  input logic      clk,
  input logic      rst_n,
  tqv_in_if.sink   in_ch,
  tqv_out_if.source out_ch,
  tqv_cfg_if.sink  cfg_ch
);
  import tqv_pkg::*;

  ctl_cmd_t  cmd;
  ctl_stat_t stat;
  in_item_t  in_item;
  out_item_t out_item;
  logic      out_valid;

  always_comb begin
    in_item.kind         = in_ch.kind;
    in_item.cur_state    = in_ch.cur_state;
    in_item.action       = in_ch.action;
    in_item.reward       = in_ch.reward;
    in_item.next_state   = in_ch.next_state;
    in_item.next_action  = in_ch.next_action;
    in_item.allowed_mask = in_ch.allowed_mask;
    in_item.explore_draw = in_ch.explore_draw;
    in_item.pick_draw    = in_ch.pick_draw;
    in_item.which_table  = in_ch.which_table;
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.chosen_action = out_item.chosen_action;
  assign out_ch.new_value     = out_item.new_value;
  assign out_ch.explored      = out_item.explored;
  assign out_ch.status        = out_item.status;
  assign cfg_ch.ready         = 1'b1;

  tqv_controller u_ctl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tqv_datapath #(
    .NUM_STATES  (NUM_STATES),
    .NUM_ACTIONS (NUM_ACTIONS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_valid (cfg_ch.valid),
    .cfg_index (cfg_ch.index),
    .cfg_data  (cfg_ch.data),
    .cmd       (cmd),
    .stat      (stat),
    .out_item  (out_item),
    .out_valid (out_valid),
    .out_ready (out_ch.ready)
  );

  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr |-> !in_ch.ready)
    else $error("input accepted during the clearing pass");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second transfer taken while an item is in work");

  a_explored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.explored) |->
      (out_ch.status == STATUS_OK && out_ch.new_value == 32'sd0))
    else $error("random selection carries an update value or error");

  a_empty_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == STATUS_EMPTY) |->
      (out_ch.new_value == 32'sd0 && out_ch.chosen_action == 3'd0 && !out_ch.explored))
    else $error("empty mask result has nonzero fields");

endmodule
